// File: rtl/iaht_pkg.sv
// Shared types and constants of the IPv4 address hash table.
// No dependencies; every other file in rtl/ but iaht_bucket_ram imports this package.
package iaht_pkg;

  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 22;
  localparam int COUNT_W  = 23;
  // Way index wide enough for the largest bucket (16 ways).
  localparam int WAY_IDX_W = 4;

  typedef logic [WAY_IDX_W-1:0] way_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND     = 3'd0,
    ST_MISS      = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // Running outcome of the way scan over one bucket.
  typedef struct packed {
    logic     hit;
    way_idx_t hit_way;
    logic     free;
    way_idx_t free_way;
  } scan_res_t;

endpackage

// File: rtl/iaht_bucket_ram.sv
// Bucket memory of the IPv4 address hash table: one row per bucket.
// One write port, one read port with registered read data. Uses no package.
module iaht_bucket_ram #(
  parameter int ADDR_W = 20,
  parameter int DATA_W = 52
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/iaht_way_scan.sv
// Shared way comparator: checks one way of a bucket per step and keeps the
// first matching way and the first free way. Depends on iaht_pkg.
module iaht_way_scan #(
  parameter int KEY_W = 12
) (
  input  logic                clk,
  input  logic                step,
  input  logic                first,
  input  iaht_pkg::way_idx_t  way,
  input  logic                entry_valid,
  input  logic [KEY_W-1:0]    entry_low,
  input  logic [KEY_W-1:0]    key_low,
  output iaht_pkg::scan_res_t res
);
  import iaht_pkg::*;

  scan_res_t res_r;
  scan_res_t base;
  scan_res_t res_nxt;
  logic      match;

  assign match = entry_valid && (entry_low == key_low);

  always_comb begin
    base = first ? '0 : res_r;
    res_nxt = base;
    if (match && !base.hit) begin
      res_nxt.hit     = 1'b1;
      res_nxt.hit_way = way;
    end
    if (!entry_valid && !base.free) begin
      res_nxt.free     = 1'b1;
      res_nxt.free_way = way;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// File: rtl/ipv4_address_hash_table.sv
// Top level of the IPv4 address hash table: sequencer, count and result.
// Depends on iaht_pkg, iaht_bucket_ram and iaht_way_scan.
//
// Exact-match table of IPv4 addresses. The bucket is address >> KEY_SHIFT;
// each bucket row holds BUCKET_WAYS ways of {valid, low KEY_SHIFT bits}.
// Input channel: an item (in_kind, in_address) is taken at a rising edge
// with start high and busy low. in_kind 0 looks the address up, 1 inserts it.
// Result channel: out_valid is high for exactly one cycle with out_status,
// out_slot and out_entry_count; the receiver cannot stall, so take it then.
// Sequence: the accept edge reads the bucket row, then the shared comparator
// checks one way per cycle in S_SCAN, then S_DONE decides and writes the
// row back. The result strobe is registered from S_DONE and is high while
// the block is idle again; a new item can be taken at the edge that ends
// the strobe, so the block takes no new item before it is through with the
// last one.
// Reset: busy rises and the block sweeps every bucket row to empty, one row
// per cycle, then drops busy. The entry count resets to zero and saturates
// at 2**23-1.
module ipv4_address_hash_table #(
  parameter int KEY_SHIFT   = 12,
  parameter int BUCKET_WAYS = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_kind,
  input  logic [31:0]                  in_address,
  output logic                         out_valid,
  output logic [iaht_pkg::STATUS_W-1:0] out_status,
  output logic [iaht_pkg::SLOT_W-1:0]   out_slot,
  output logic [iaht_pkg::COUNT_W-1:0]  out_entry_count
);
  import iaht_pkg::*;

  localparam int BKT_W       = 32 - KEY_SHIFT;
  localparam int ENT_W       = KEY_SHIFT + 1;
  localparam int ROW_W       = BUCKET_WAYS * ENT_W;
  localparam int WAY_W       = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
  localparam int SLOT_FULL_W = BKT_W + $clog2(BUCKET_WAYS + 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  logic [BKT_W-1:0]       clr_idx_r, clr_idx_nxt;
  logic [WAY_W-1:0]       way_cnt_r, way_cnt_nxt;
  logic [BKT_W-1:0]       bucket_r;
  logic [KEY_SHIFT-1:0]   key_low_r;
  logic                   kind_r;
  logic [SLOT_FULL_W-1:0] base_r;
  logic [COUNT_W-1:0]     count_r, count_nxt;
  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]      out_slot_r, out_slot_nxt;

  logic                   accept;
  logic                   ram_wr_en;
  logic [BKT_W-1:0]       ram_wr_addr;
  logic [ROW_W-1:0]       ram_wr_data;
  logic [ROW_W-1:0]       row;
  logic [ROW_W-1:0]       new_row;
  logic [ENT_W-1:0]       cur_entry;
  logic                   scan_step;
  scan_res_t              scan_res;
  logic [SLOT_FULL_W-1:0] hit_slot;
  logic [SLOT_FULL_W-1:0] free_slot;
  logic                   do_insert;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  iaht_bucket_ram #(
    .ADDR_W (BKT_W),
    .DATA_W (ROW_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (accept),
    .rd_addr (in_address[31:KEY_SHIFT]),
    .rd_data (row)
  );

  // Feed the shared comparator one way of the held row per cycle.
  assign cur_entry = row[way_cnt_r*ENT_W +: ENT_W];
  assign scan_step = (state_r == S_SCAN);

  iaht_way_scan #(
    .KEY_W (KEY_SHIFT)
  ) u_scan (
    .clk         (clk),
    .step        (scan_step),
    .first       (way_cnt_r == '0),
    .way         (WAY_IDX_W'(way_cnt_r)),
    .entry_valid (cur_entry[KEY_SHIFT]),
    .entry_low   (cur_entry[KEY_SHIFT-1:0]),
    .key_low     (key_low_r),
    .res         (scan_res)
  );

  assign hit_slot  = base_r + SLOT_FULL_W'(scan_res.hit_way);
  assign free_slot = base_r + SLOT_FULL_W'(scan_res.free_way);
  assign do_insert = (state_r == S_DONE) && kind_r && !scan_res.hit && scan_res.free;

  // Replace the free way with the new entry; keep the other ways.
  always_comb begin
    new_row = row;
    for (int w = 0; w < BUCKET_WAYS; w++) begin
      if (WAY_IDX_W'(w) == scan_res.free_way) begin
        new_row[w*ENT_W +: ENT_W] = {1'b1, key_low_r};
      end
    end
  end

  // Write port: clearing sweep after reset, else write-back of an insert.
  always_comb begin
    if (state_r == S_CLEAR) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_idx_r;
      ram_wr_data = '0;
    end else begin
      ram_wr_en   = do_insert;
      ram_wr_addr = bucket_r;
      ram_wr_data = new_row;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    way_cnt_nxt    = way_cnt_r;
    count_nxt      = count_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    case (state_r)
      S_CLEAR: begin
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          way_cnt_nxt = '0;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        way_cnt_nxt = way_cnt_r + 1'b1;
        if (way_cnt_r == WAY_W'(BUCKET_WAYS - 1)) begin
          way_cnt_nxt = '0;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_slot_nxt  = '0;
        if (!kind_r) begin
          if (scan_res.hit) begin
            out_status_nxt = ST_FOUND;
            out_slot_nxt   = SLOT_W'(hit_slot);
          end else begin
            out_status_nxt = ST_MISS;
          end
        end else if (scan_res.hit) begin
          out_status_nxt = ST_DUPLICATE;
          out_slot_nxt   = SLOT_W'(hit_slot);
        end else if (scan_res.free) begin
          out_status_nxt = ST_INSERTED;
          out_slot_nxt   = SLOT_W'(free_slot);
          if (count_r != '1) begin
            count_nxt = count_r + 1'b1;
          end
        end else begin
          out_status_nxt = ST_FULL;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      way_cnt_r    <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      out_status_r <= ST_MISS;
      out_slot_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      way_cnt_r    <= way_cnt_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
      out_slot_r   <= out_slot_nxt;
    end
  end

  // Capture the item and the bucket base slot at accept.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r    <= in_kind;
      bucket_r  <= in_address[31:KEY_SHIFT];
      key_low_r <= in_address[KEY_SHIFT-1:0];
      base_r    <= SLOT_FULL_W'(in_address[31:KEY_SHIFT]) * SLOT_FULL_W'(BUCKET_WAYS);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot        = out_slot_r;
  assign out_entry_count = count_r;

endmodule

// File: rtl/iaht_checker.sv
// Port-level checks of the IPv4 address hash table, bound to the top level.
// Depends on iaht_pkg and ipv4_address_hash_table.
module iaht_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [iaht_pkg::STATUS_W-1:0] out_status,
  input logic [iaht_pkg::SLOT_W-1:0]   out_slot
);
  import iaht_pkg::*;

  // An accepted item occupies the block in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // A result strobe lasts one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // A result shows up only once the block is free again.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // Status is a legal code; miss and full report slot zero.
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_FULL))
    else $error("illegal status code");

  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_MISS || out_status == ST_FULL) |-> out_slot == '0)
    else $error("miss or full result with nonzero slot");

endmodule

bind ipv4_address_hash_table iaht_checker u_iaht_checker (.*);
